// ----- sv/illm_pkg.sv -----
// ----------------------------------------------------------------------------
// illm_pkg
// shared sizes, request and status codes and sequencer states of the
// indexed linked list manager
// ----------------------------------------------------------------------------
package illm_pkg;

   localparam int CAPACITY = 256;
   localparam int VALUE_W  = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int PTR_W    = $clog2(CAPACITY + 1);

   localparam logic [PTR_W-1:0] NONE_PTR = PTR_W'(CAPACITY);

   localparam logic [3:0] OP_PUSH_FRONT   = 4'd0;
   localparam logic [3:0] OP_PUSH_BACK    = 4'd1;
   localparam logic [3:0] OP_POP_FRONT    = 4'd2;
   localparam logic [3:0] OP_INSERT       = 4'd3;
   localparam logic [3:0] OP_REMOVE       = 4'd4;
   localparam logic [3:0] OP_REVERSE      = 4'd5;
   localparam logic [3:0] OP_READ         = 4'd6;
   localparam logic [3:0] OP_WRITE        = 4'd7;
   localparam logic [3:0] OP_STEP         = 4'd8;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_BAD_POS  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST,
      S_SECOND,
      S_LINK_WR,
      S_WALK
   } illm_state_type;

endpackage

// ----- sv/indexed_linked_list_manager.sv -----
// push_front, push_back, pop_front, write_at, step and errors give their result from
// S_FIRST; insert_before, remove_at and read_at give theirs from S_SECOND
// one request at a time, set by the single read and write port of the link table:
// a new request is taken only in S_IDLE; reverse walks in S_WALK, one entry a cycle
// reset: pointers and count clear at once; per-entry written bits make the link
// table read as the full free chain, so no clearing pass is needed
// ----------------------------------------------------------------------------
// indexed_linked_list_manager
// singly linked list in a fixed table with a free chain, driven by a small
// sequencer around a link memory and a value memory
// ----------------------------------------------------------------------------
module indexed_linked_list_manager (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value[31:0], position_index[39:32]
   input  logic [4:0]  req_tuser,   // req_type[3:0], position_at_head[4]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // value_out[31:0], index_out[40:32], list_size[49:41]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int IW = illm_pkg::IDX_W;
   localparam int PW = illm_pkg::PTR_W;
   localparam int VW = illm_pkg::VALUE_W;

   logic [PW-1:0] link_mem [illm_pkg::CAPACITY];
   logic [VW-1:0] value_mem [illm_pkg::CAPACITY];

   illm_pkg::illm_state_type state_ff, state_in;

   logic [3:0]    op_ff, op_in;
   logic [VW-1:0] val_ff, val_in;
   logic [7:0]    pidx_ff, pidx_in;
   logic          at_head_ff, at_head_in;
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [PW-1:0] free_ff, free_in;
   logic [PW-1:0] count_ff, count_in;
   logic [PW-1:0] aux_ff, aux_in;
   logic [PW-1:0] walk_ff, walk_in;
   logic [PW-1:0] back_ff, back_in;
   logic [PW-1:0] wa_ff, wa_in;
   logic [PW-1:0] wd_ff, wd_in;

   logic [illm_pkg::CAPACITY-1:0] live_ff;
   logic [illm_pkg::CAPACITY-1:0] written_ff;
   logic                          live_q_ff;

   logic          link_re, link_we;
   logic [IW-1:0] link_ra, link_wa;
   logic [PW-1:0] link_wd;
   logic [PW-1:0] link_q_ff;
   logic [IW-1:0] rd_addr_ff;
   logic          rd_written_ff;
   logic [PW-1:0] link_rd;

   logic          value_re, value_we;
   logic [IW-1:0] value_ra, value_wa;
   logic [VW-1:0] value_wd;
   logic [VW-1:0] value_q_ff;

   logic          live_we, live_val;
   logic [IW-1:0] live_addr;

   logic          done;
   logic [1:0]    status_c;
   logic [VW-1:0] vout_c;
   logic [PW-1:0] iout_c;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff;
   logic [VW-1:0] rsp_value_ff;
   logic [PW-1:0] rsp_index_ff;
   logic [PW-1:0] rsp_size_ff;

   logic          req_fire;
   logic [PW-1:0] pidx_ext;
   logic [PW-1:0] prev_c;
   logic [PW-1:0] curr_c;
   logic          pos_ok_c;

   assign req_fire = req_tvalid && req_tready;
   assign pidx_ext = PW'(pidx_ff);
   assign prev_c   = at_head_ff ? illm_pkg::NONE_PTR : pidx_ext;
   assign pos_ok_c = at_head_ff || live_q_ff;
   assign curr_c   = at_head_ff ? head_ff : link_rd;

   // unwritten entries still hold the reset free chain
   assign link_rd = rd_written_ff ? link_q_ff :
                    ((rd_addr_ff == '0) ? illm_pkg::NONE_PTR : PW'(rd_addr_ff) - 1'b1);

   // link memory and its written bits
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (link_re) begin
         link_q_ff  <= link_mem[link_ra];
         rd_addr_ff <= link_ra;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (link_we) begin
            written_ff[link_wa] <= 1'b1;
         end
         if (link_re) begin
            rd_written_ff <= written_ff[link_ra];
         end
      end
   end

   // value memory
   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[value_wa] <= value_wd;
      end
      if (value_re) begin
         value_q_ff <= value_mem[value_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= illm_pkg::S_IDLE;
         head_ff      <= illm_pkg::NONE_PTR;
         tail_ff      <= illm_pkg::NONE_PTR;
         free_ff      <= PW'(illm_pkg::CAPACITY - 1);
         count_ff     <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (live_we) begin
            live_ff[live_addr] <= live_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      val_ff     <= val_in;
      pidx_ff    <= pidx_in;
      at_head_ff <= at_head_in;
      aux_ff     <= aux_in;
      walk_ff    <= walk_in;
      back_ff    <= back_in;
      wa_ff      <= wa_in;
      wd_ff      <= wd_in;
      if (req_fire) begin
         live_q_ff <= live_ff[req_tdata[39:32]];
      end
      if (done) begin
         rsp_status_ff <= status_c;
         rsp_value_ff  <= vout_c;
         rsp_index_ff  <= iout_c;
         rsp_size_ff   <= count_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      val_in     = val_ff;
      pidx_in    = pidx_ff;
      at_head_in = at_head_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      free_in    = free_ff;
      count_in   = count_ff;
      aux_in     = aux_ff;
      walk_in    = walk_ff;
      back_in    = back_ff;
      wa_in      = wa_ff;
      wd_in      = wd_ff;
      link_re    = 1'b0;
      link_ra    = '0;
      link_we    = 1'b0;
      link_wa    = '0;
      link_wd    = '0;
      value_re   = 1'b0;
      value_ra   = '0;
      value_we   = 1'b0;
      value_wa   = '0;
      value_wd   = val_ff;
      live_we    = 1'b0;
      live_addr  = '0;
      live_val   = 1'b0;
      done       = 1'b0;
      status_c   = illm_pkg::STATUS_OK;
      vout_c     = '0;
      iout_c     = illm_pkg::NONE_PTR;
      req_tready = 1'b0;

      case (state_ff)
         illm_pkg::S_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            if (req_fire) begin
               op_in      = req_tuser[3:0];
               at_head_in = req_tuser[4];
               val_in     = req_tdata[VW-1:0];
               pidx_in    = req_tdata[39:32];
               link_re    = 1'b1;
               state_in   = illm_pkg::S_FIRST;
               case (req_tuser[3:0])
                  illm_pkg::OP_PUSH_FRONT, illm_pkg::OP_PUSH_BACK: begin
                     link_ra = free_ff[IW-1:0];
                  end
                  illm_pkg::OP_POP_FRONT: begin
                     link_ra  = head_ff[IW-1:0];
                     value_re = 1'b1;
                     value_ra = head_ff[IW-1:0];
                  end
                  illm_pkg::OP_REVERSE: begin
                     link_ra  = head_ff[IW-1:0];
                     walk_in  = head_ff;
                     back_in  = illm_pkg::NONE_PTR;
                     state_in = illm_pkg::S_WALK;
                  end
                  default: begin
                     link_ra = IW'(req_tdata[39:32]);
                  end
               endcase
            end
         end

         illm_pkg::S_FIRST: begin
            state_in = illm_pkg::S_IDLE;
            case (op_ff)
               illm_pkg::OP_PUSH_FRONT: begin
                  done = 1'b1;
                  if (free_ff == illm_pkg::NONE_PTR) begin
                     status_c = illm_pkg::STATUS_FULL;
                  end else begin
                     free_in   = link_rd;
                     link_we   = 1'b1;
                     link_wa   = free_ff[IW-1:0];
                     link_wd   = head_ff;
                     value_we  = 1'b1;
                     value_wa  = free_ff[IW-1:0];
                     live_we   = 1'b1;
                     live_addr = free_ff[IW-1:0];
                     live_val  = 1'b1;
                     head_in   = free_ff;
                     if (count_ff == '0) begin
                        tail_in = free_ff;
                     end
                     count_in  = count_ff + 1'b1;
                     iout_c    = free_ff;
                  end
               end
               illm_pkg::OP_PUSH_BACK: begin
                  done = 1'b1;
                  if (free_ff == illm_pkg::NONE_PTR) begin
                     status_c = illm_pkg::STATUS_FULL;
                  end else begin
                     free_in   = link_rd;
                     link_we   = 1'b1;
                     link_wa   = free_ff[IW-1:0];
                     link_wd   = illm_pkg::NONE_PTR;
                     value_we  = 1'b1;
                     value_wa  = free_ff[IW-1:0];
                     live_we   = 1'b1;
                     live_addr = free_ff[IW-1:0];
                     live_val  = 1'b1;
                     if (tail_ff != illm_pkg::NONE_PTR) begin
                        wa_in    = tail_ff;
                        wd_in    = free_ff;
                        state_in = illm_pkg::S_LINK_WR;
                     end else begin
                        head_in = free_ff;
                     end
                     tail_in   = free_ff;
                     count_in  = count_ff + 1'b1;
                     iout_c    = free_ff;
                  end
               end
               illm_pkg::OP_POP_FRONT: begin
                  done = 1'b1;
                  if (count_ff == '0 || head_ff == illm_pkg::NONE_PTR) begin
                     status_c = illm_pkg::STATUS_BAD_POS;
                  end else begin
                     vout_c    = value_q_ff;
                     head_in   = link_rd;
                     if (count_ff == PW'(1)) begin
                        tail_in = illm_pkg::NONE_PTR;
                     end
                     link_we   = 1'b1;
                     link_wa   = head_ff[IW-1:0];
                     link_wd   = free_ff;
                     free_in   = head_ff;
                     live_we   = 1'b1;
                     live_addr = head_ff[IW-1:0];
                     live_val  = 1'b0;
                     count_in  = count_ff - 1'b1;
                  end
               end
               illm_pkg::OP_INSERT: begin
                  if (free_ff == illm_pkg::NONE_PTR) begin
                     done     = 1'b1;
                     status_c = illm_pkg::STATUS_FULL;
                  end else if (!pos_ok_c) begin
                     done     = 1'b1;
                     status_c = illm_pkg::STATUS_BAD_POS;
                  end else begin
                     aux_in   = curr_c;
                     link_re  = 1'b1;
                     link_ra  = free_ff[IW-1:0];
                     state_in = illm_pkg::S_SECOND;
                  end
               end
               illm_pkg::OP_REMOVE, illm_pkg::OP_READ, illm_pkg::OP_WRITE,
               illm_pkg::OP_STEP: begin
                  if (!pos_ok_c || curr_c == illm_pkg::NONE_PTR) begin
                     done     = 1'b1;
                     status_c = illm_pkg::STATUS_BAD_POS;
                  end else begin
                     aux_in = curr_c;
                     case (op_ff)
                        illm_pkg::OP_REMOVE: begin
                           link_re  = 1'b1;
                           link_ra  = curr_c[IW-1:0];
                           state_in = illm_pkg::S_SECOND;
                        end
                        illm_pkg::OP_READ: begin
                           value_re = 1'b1;
                           value_ra = curr_c[IW-1:0];
                           state_in = illm_pkg::S_SECOND;
                        end
                        illm_pkg::OP_WRITE: begin
                           value_we = 1'b1;
                           value_wa = curr_c[IW-1:0];
                           done     = 1'b1;
                        end
                        default: begin
                           iout_c = curr_c;
                           done   = 1'b1;
                        end
                     endcase
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end

         illm_pkg::S_SECOND: begin
            state_in = illm_pkg::S_IDLE;
            done     = 1'b1;
            case (op_ff)
               illm_pkg::OP_INSERT: begin
                  free_in   = link_rd;
                  live_we   = 1'b1;
                  live_addr = free_ff[IW-1:0];
                  live_val  = 1'b1;
                  value_we  = 1'b1;
                  value_wa  = free_ff[IW-1:0];
                  link_we   = 1'b1;
                  link_wa   = free_ff[IW-1:0];
                  link_wd   = aux_ff;
                  if (prev_c == tail_ff) begin
                     tail_in = free_ff;
                  end
                  if (at_head_ff) begin
                     head_in = free_ff;
                  end else begin
                     wa_in    = pidx_ext;
                     wd_in    = free_ff;
                     state_in = illm_pkg::S_LINK_WR;
                  end
                  count_in  = count_ff + 1'b1;
                  iout_c    = free_ff;
               end
               illm_pkg::OP_REMOVE: begin
                  if (aux_ff == tail_ff) begin
                     tail_in = prev_c;
                  end
                  link_we   = 1'b1;
                  link_wa   = aux_ff[IW-1:0];
                  link_wd   = free_ff;
                  free_in   = aux_ff;
                  live_we   = 1'b1;
                  live_addr = aux_ff[IW-1:0];
                  live_val  = 1'b0;
                  count_in  = count_ff - 1'b1;
                  if (at_head_ff) begin
                     head_in = link_rd;
                  end else begin
                     wa_in    = pidx_ext;
                     wd_in    = link_rd;
                     state_in = illm_pkg::S_LINK_WR;
                  end
               end
               illm_pkg::OP_READ: begin
                  vout_c = value_q_ff;
               end
               default: begin
                  status_c = illm_pkg::STATUS_OK;
               end
            endcase
         end

         illm_pkg::S_LINK_WR: begin
            link_we  = 1'b1;
            link_wa  = wa_ff[IW-1:0];
            link_wd  = wd_ff;
            state_in = illm_pkg::S_IDLE;
         end

         illm_pkg::S_WALK: begin
            if (walk_ff == illm_pkg::NONE_PTR) begin
               head_in  = tail_ff;
               tail_in  = head_ff;
               done     = 1'b1;
               state_in = illm_pkg::S_IDLE;
            end else begin
               link_we = 1'b1;
               link_wa = walk_ff[IW-1:0];
               link_wd = back_ff;
               back_in = walk_ff;
               walk_in = link_rd;
               if (link_rd != illm_pkg::NONE_PTR) begin
                  link_re = 1'b1;
                  link_ra = link_rd[IW-1:0];
               end
            end
         end

         default: begin
            state_in = illm_pkg::S_IDLE;
         end
      endcase

      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'd0, rsp_size_ff, rsp_index_ff, rsp_value_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= illm_pkg::NONE_PTR)
      else $error("element count above capacity");

   a_ends_agree: assert property (@(posedge clock) disable iff (reset)
      state_ff == illm_pkg::S_IDLE |->
         ((head_ff == illm_pkg::NONE_PTR) == (tail_ff == illm_pkg::NONE_PTR)))
      else $error("head and tail disagree on an empty list");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == illm_pkg::S_IDLE |->
         ((count_ff == '0) == (head_ff == illm_pkg::NONE_PTR)))
      else $error("count and head disagree");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == illm_pkg::S_IDLE && free_ff == illm_pkg::NONE_PTR) |->
         count_ff == illm_pkg::NONE_PTR)
      else $error("free chain empty with room left");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result overwritten before taken");
`endif

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the indexed linked list manager. Requests go in over the
// req stream with random gaps and results are taken off the rsp stream with
// random stalls and one long hold-off. A shadow copy of the link table, value
// table and free chain predicts every result, and a checker compares each
// result field by field with the oldest prediction. The run covers a directed
// walk through every operation and the bad-position errors, a fill to full
// capacity and a drain back to empty, and a random mix of list operations.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] OP_SPARE_LO = 4'd9;
   localparam logic [3:0] OP_SPARE_HI = 4'd15;
   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_COUNT  = 20;

   typedef struct packed {
      logic [1:0]                   status;
      logic [illm_pkg::VALUE_W-1:0] value_out;
      logic [illm_pkg::PTR_W-1:0]   index_out;
      logic [illm_pkg::PTR_W-1:0]   list_size;
   } list_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // value[31:0], position_index[39:32]
   logic [4:0]  req_tuser = '0;   // req_type[3:0], position_at_head[4]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // value_out[31:0], index_out[40:32], list_size[49:41]
   logic [1:0]  rsp_tuser;        // status[1:0]

   // shadow list state
   logic [illm_pkg::PTR_W-1:0]   link_next   [illm_pkg::CAPACITY];
   logic [illm_pkg::VALUE_W-1:0] value_store [illm_pkg::CAPACITY];
   bit                           in_list     [illm_pkg::CAPACITY];
   logic [illm_pkg::PTR_W-1:0]   head_idx;
   logic [illm_pkg::PTR_W-1:0]   tail_idx;
   logic [illm_pkg::PTR_W-1:0]   free_idx;
   int                           elem_total;

   list_result_type expected_results[$];

   int send_gap_max = 15;
   int recv_stall_max = 15;
   int recv_hold = 0;
   int requests_sent = 0;
   int responses_seen = 0;
   int mismatch_count = 0;
   int input_stall_cycles = 0;
   int held_cycles = 0;
   int full_hits = 0;
   int cycle_count = 0;

   indexed_linked_list_manager dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("indexed_linked_list_manager regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // shadow model
   // ------------------------------------------------------------------------
   function automatic void clear_list_model();
      for (int i = 0; i < illm_pkg::CAPACITY; i++) begin
         link_next[i] = (i == 0) ? illm_pkg::NONE_PTR : illm_pkg::PTR_W'(i - 1);
         value_store[i] = '0;
         in_list[i] = 1'b0;
      end
      head_idx = illm_pkg::NONE_PTR;
      tail_idx = illm_pkg::NONE_PTR;
      free_idx = illm_pkg::PTR_W'(illm_pkg::CAPACITY - 1);
      elem_total = 0;
   endfunction

   function automatic logic [illm_pkg::PTR_W-1:0] claim_entry();
      logic [illm_pkg::PTR_W-1:0] e;
      e = free_idx;
      free_idx = link_next[e];
      link_next[e] = illm_pkg::NONE_PTR;
      in_list[e] = 1'b1;
      return e;
   endfunction

   function automatic void release_entry(input logic [illm_pkg::PTR_W-1:0] e);
      link_next[e] = free_idx;
      free_idx = e;
      in_list[e] = 1'b0;
   endfunction

   function automatic list_result_type apply_list_op(
         input logic [3:0] op,
         input logic [illm_pkg::VALUE_W-1:0] val,
         input logic [illm_pkg::IDX_W-1:0] pidx,
         input logic at_head);
      list_result_type res;
      logic [illm_pkg::PTR_W-1:0] prev, curr, e, back, walk, nx;
      bit pos_ok;
      int n;
      res.status = illm_pkg::STATUS_OK;
      res.value_out = '0;
      res.index_out = illm_pkg::NONE_PTR;
      prev = illm_pkg::NONE_PTR;
      curr = illm_pkg::NONE_PTR;
      pos_ok = 1'b1;
      if (at_head)
         curr = head_idx;
      else if (in_list[pidx]) begin
         prev = illm_pkg::PTR_W'(pidx);
         curr = link_next[pidx];
      end else
         pos_ok = 1'b0;
      if (curr >= illm_pkg::CAPACITY)
         curr = illm_pkg::NONE_PTR;

      case (op)
         illm_pkg::OP_PUSH_FRONT, illm_pkg::OP_PUSH_BACK: begin
            if (free_idx >= illm_pkg::CAPACITY) begin
               res.status = illm_pkg::STATUS_FULL;
            end else begin
               e = claim_entry();
               value_store[e] = val;
               if (op == illm_pkg::OP_PUSH_FRONT) begin
                  link_next[e] = head_idx;
                  head_idx = e;
                  if (elem_total == 0)
                     tail_idx = e;
               end else begin
                  if (tail_idx < illm_pkg::CAPACITY)
                     link_next[tail_idx] = e;
                  else
                     head_idx = e;
                  tail_idx = e;
               end
               elem_total++;
               res.index_out = e;
            end
         end
         illm_pkg::OP_POP_FRONT: begin
            if (elem_total == 0 || head_idx >= illm_pkg::CAPACITY) begin
               res.status = illm_pkg::STATUS_BAD_POS;
            end else begin
               e = head_idx;
               res.value_out = value_store[e];
               head_idx = link_next[e];
               if (elem_total == 1)
                  tail_idx = illm_pkg::NONE_PTR;
               release_entry(e);
               elem_total--;
            end
         end
         illm_pkg::OP_INSERT: begin
            if (free_idx >= illm_pkg::CAPACITY) begin
               res.status = illm_pkg::STATUS_FULL;
            end else if (!pos_ok) begin
               res.status = illm_pkg::STATUS_BAD_POS;
            end else begin
               e = claim_entry();
               if (prev == tail_idx)
                  tail_idx = e;
               if (prev == illm_pkg::NONE_PTR)
                  head_idx = e;
               else
                  link_next[prev] = e;
               link_next[e] = curr;
               value_store[e] = val;
               elem_total++;
               res.index_out = e;
            end
         end
         illm_pkg::OP_REMOVE: begin
            if (!pos_ok || curr == illm_pkg::NONE_PTR) begin
               res.status = illm_pkg::STATUS_BAD_POS;
            end else begin
               if (curr == tail_idx)
                  tail_idx = prev;
               if (prev == illm_pkg::NONE_PTR)
                  head_idx = link_next[curr];
               else
                  link_next[prev] = link_next[curr];
               release_entry(curr);
               elem_total--;
            end
         end
         illm_pkg::OP_REVERSE: begin
            back = illm_pkg::NONE_PTR;
            walk = head_idx;
            n = 0;
            while (walk < illm_pkg::CAPACITY && n < illm_pkg::CAPACITY) begin
               nx = link_next[walk];
               link_next[walk] = back;
               back = walk;
               walk = nx;
               n++;
            end
            nx = head_idx;
            head_idx = tail_idx;
            tail_idx = nx;
         end
         illm_pkg::OP_READ, illm_pkg::OP_WRITE, illm_pkg::OP_STEP: begin
            if (!pos_ok || curr == illm_pkg::NONE_PTR)
               res.status = illm_pkg::STATUS_BAD_POS;
            else if (op == illm_pkg::OP_READ)
               res.value_out = value_store[curr];
            else if (op == illm_pkg::OP_WRITE)
               value_store[curr] = val;
            else
               res.index_out = curr;
         end
         default: ;
      endcase
      res.list_size = illm_pkg::PTR_W'(elem_total);
      return res;
   endfunction

   function automatic logic [illm_pkg::IDX_W-1:0] nth_live(input int k);
      logic [illm_pkg::PTR_W-1:0] walk;
      walk = head_idx;
      repeat (k) walk = link_next[walk];
      return walk[illm_pkg::IDX_W-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   task automatic send_request(input logic [3:0] op,
                               input logic [illm_pkg::VALUE_W-1:0] val,
                               input logic [illm_pkg::IDX_W-1:0] pidx,
                               input logic at_head);
      int gap;
      list_result_type res;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {pidx, val};
      req_tuser <= {at_head, op};
      do begin
         @(posedge clock);
         if (!req_tready)
            input_stall_cycles++;
      end while (!req_tready);
      res = apply_list_op(op, val, pidx, at_head);
      if (res.status == illm_pkg::STATUS_FULL)
         full_hits++;
      expected_results.push_back(res);
      requests_sent++;
   endtask

   task automatic send_random_request();
      logic [3:0] op;
      logic [illm_pkg::IDX_W-1:0] pidx;
      logic at_head;
      int r;
      r = $urandom_range(0, 99);
      if (r < 14)      op = illm_pkg::OP_PUSH_FRONT;
      else if (r < 28) op = illm_pkg::OP_PUSH_BACK;
      else if (r < 40) op = illm_pkg::OP_POP_FRONT;
      else if (r < 52) op = illm_pkg::OP_INSERT;
      else if (r < 64) op = illm_pkg::OP_REMOVE;
      else if (r < 68) op = illm_pkg::OP_REVERSE;
      else if (r < 78) op = illm_pkg::OP_READ;
      else if (r < 88) op = illm_pkg::OP_WRITE;
      else if (r < 97) op = illm_pkg::OP_STEP;
      else             op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      // keep the list from growing without bound
      if (elem_total > 64 && r < 28)
         op = illm_pkg::OP_POP_FRONT;
      pidx = illm_pkg::IDX_W'($urandom);
      at_head = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 15)
         at_head = 1'b1;
      else if (r >= 25 && elem_total > 0) begin
         if (r < 35)
            pidx = tail_idx[illm_pkg::IDX_W-1:0];
         else
            pidx = nth_live($urandom_range(0, elem_total - 1));
      end
      send_request(op, $urandom, pidx, at_head);
   endtask

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------
   initial begin
      int stall;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (recv_hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (recv_hold) begin
               @(posedge clock);
               held_cycles++;
            end
            recv_hold = 0;
         end else begin
            stall = $urandom_range(0, recv_stall_max);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid && recv_hold == 0);
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on %s at response %0d: got 0x%0h, want 0x%0h",
               what, responses_seen, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch("response with no request pending", rsp_tdata, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser !== want.status)
               report_mismatch("status", rsp_tuser, want.status);
            if (rsp_tdata[31:0] !== want.value_out)
               report_mismatch("value_out", rsp_tdata[31:0], want.value_out);
            if (rsp_tdata[40:32] !== want.index_out)
               report_mismatch("index_out", rsp_tdata[40:32], want.index_out);
            if (rsp_tdata[49:41] !== want.list_size)
               report_mismatch("list_size", rsp_tdata[49:41], want.list_size);
            if (rsp_tdata[55:50] !== '0)
               report_mismatch("tdata padding", rsp_tdata[55:50], 0);
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_each_operation();
      send_request(illm_pkg::OP_POP_FRONT, '0, '0, 1'b0);
      send_request(illm_pkg::OP_READ, '1, '1, 1'b1);
      send_request(illm_pkg::OP_REVERSE, '0, '0, 1'b1);
      send_request(illm_pkg::OP_INSERT, 32'h0000_0001, '0, 1'b1);
      send_request(illm_pkg::OP_PUSH_FRONT, '1, '0, 1'b0);
      send_request(illm_pkg::OP_PUSH_BACK, '0, '1, 1'b1);
      send_request(illm_pkg::OP_INSERT, 32'hA5A5_5A5A,
                   head_idx[illm_pkg::IDX_W-1:0], 1'b0);
      send_request(illm_pkg::OP_INSERT, 32'h5A5A_A5A5,
                   tail_idx[illm_pkg::IDX_W-1:0], 1'b0);
      send_request(illm_pkg::OP_READ, '0, '0, 1'b1);
      send_request(illm_pkg::OP_WRITE, 32'h8000_0000,
                   head_idx[illm_pkg::IDX_W-1:0], 1'b0);
      send_request(illm_pkg::OP_READ, '0, head_idx[illm_pkg::IDX_W-1:0], 1'b0);
      send_request(illm_pkg::OP_STEP, '0, '0, 1'b1);
      send_request(illm_pkg::OP_STEP, '0, head_idx[illm_pkg::IDX_W-1:0], 1'b0);
      // past the end of the list
      send_request(illm_pkg::OP_STEP, '0, tail_idx[illm_pkg::IDX_W-1:0], 1'b0);
      send_request(illm_pkg::OP_REMOVE, '0, tail_idx[illm_pkg::IDX_W-1:0], 1'b0);
      send_request(illm_pkg::OP_WRITE, '1, tail_idx[illm_pkg::IDX_W-1:0], 1'b0);
      // entry not in the list
      send_request(illm_pkg::OP_READ, '0, '0, 1'b0);
      send_request(illm_pkg::OP_INSERT, '1, '0, 1'b0);
      send_request(illm_pkg::OP_REVERSE, '0, '0, 1'b0);
      send_request(illm_pkg::OP_READ, '0, '0, 1'b1);
      send_request(illm_pkg::OP_REMOVE, '0, '0, 1'b1);
      send_request(illm_pkg::OP_REMOVE, '0, head_idx[illm_pkg::IDX_W-1:0], 1'b0);
      send_request(illm_pkg::OP_POP_FRONT, '0, '0, 1'b0);
      send_request(OP_SPARE_LO, '0, '0, 1'b0);
      send_request(OP_SPARE_HI, '1, '1, 1'b1);
   endtask

   task automatic test_fill_and_drain();
      int r;
      while (free_idx < illm_pkg::CAPACITY) begin
         r = $urandom_range(0, 2);
         if (r == 0)
            send_request(illm_pkg::OP_PUSH_FRONT, $urandom,
                         illm_pkg::IDX_W'($urandom), 1'b0);
         else if (r == 1)
            send_request(illm_pkg::OP_PUSH_BACK, $urandom,
                         illm_pkg::IDX_W'($urandom), 1'b1);
         else
            send_request(illm_pkg::OP_INSERT, $urandom,
                         nth_live($urandom_range(0, elem_total - 1)), 1'b0);
      end
      send_request(illm_pkg::OP_PUSH_FRONT, '1, '0, 1'b0);
      send_request(illm_pkg::OP_PUSH_BACK, '1, '0, 1'b0);
      send_request(illm_pkg::OP_INSERT, '1, '0, 1'b1);
      send_request(illm_pkg::OP_INSERT, '1, tail_idx[illm_pkg::IDX_W-1:0], 1'b0);
      send_request(illm_pkg::OP_REVERSE, '0, '0, 1'b0);
      send_request(illm_pkg::OP_READ, '0, nth_live(illm_pkg::CAPACITY / 2), 1'b0);
      send_request(illm_pkg::OP_STEP, '0, tail_idx[illm_pkg::IDX_W-1:0], 1'b0);
      while (elem_total > 0) begin
         r = $urandom_range(0, 2);
         if (r == 0)
            send_request(illm_pkg::OP_POP_FRONT, $urandom,
                         illm_pkg::IDX_W'($urandom), 1'b0);
         else if (r == 1)
            send_request(illm_pkg::OP_REMOVE, $urandom,
                         illm_pkg::IDX_W'($urandom), 1'b1);
         else
            send_request(illm_pkg::OP_REMOVE, $urandom,
                         nth_live($urandom_range(0, elem_total - 1)), 1'b0);
      end
      send_request(illm_pkg::OP_POP_FRONT, '0, '0, 1'b1);
   endtask

   task automatic test_random_mix();
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         send_random_request();
      end
   endtask

   task automatic test_output_backpressure();
      recv_hold = HOLD_CYCLES;
      repeat (30) send_random_request();
      repeat (10) send_random_request();
   endtask

   initial begin
      clear_list_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_each_operation();
      test_fill_and_drain();
      test_random_mix();
      test_output_backpressure();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("ran %0d requests and checked %0d results, %0d of them table-full",
               requests_sent, responses_seen, full_hits);
      $display("result side held off %0d cycles, input stalled %0d cycles, %0d mismatches",
               held_cycles, input_stall_cycles, mismatch_count);
      if (mismatch_count == 0)
         $display("indexed_linked_list_manager regression: pass");
      else
         $display("indexed_linked_list_manager regression: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/illm_pkg.sv
sv/indexed_linked_list_manager.sv
test/tb_top.sv
